// ----- rtl/kac_pkg.sv -----
// ----------------------------------------------------------------------------
// kac_pkg
// Shared constants, codes and types for the label agreement check.
// ----------------------------------------------------------------------------
package kac_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_FEATURES = 64;
  localparam int MAX_K        = 16;

  localparam int PIDX_W  = $clog2(MAX_POINTS);
  localparam int FIDX_W  = $clog2(MAX_FEATURES);
  localparam int REF_AW  = PIDX_W + FIDX_W;
  localparam int NPTS_W  = 11;
  localparam int NFEAT_W = 7;
  localparam int K_W     = 5;
  localparam int FEAT_W  = 16;
  localparam int LABEL_W = 8;
  localparam int DIST_W  = 40;
  localparam int SQ_W    = 2 * (FEAT_W + 1);

  localparam logic [1:0] CMD_REF_FEAT  = 2'd0;
  localparam logic [1:0] CMD_REF_LABEL = 2'd1;
  localparam logic [1:0] CMD_QUERY     = 2'd2;

  localparam logic [1:0] REG_NEIGHBOR_COUNT = 2'd0;
  localparam logic [1:0] REG_POINT_COUNT    = 2'd1;
  localparam logic [1:0] REG_FEATURE_COUNT  = 2'd2;

  typedef struct packed {
    logic                vld;
    logic [DIST_W-1:0]   dsum;
    logic [LABEL_W-1:0]  lab;
  } kac_entry_t;

endpackage

// ----- rtl/kac_in_if.sv -----
// ----------------------------------------------------------------------------
// kac_in_if / kac_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface kac_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [9:0]  point_index;
  logic [5:0]  feature_index;
  logic signed [15:0] feature_value;
  logic [7:0]  class_label;

  modport source (output valid, cmd, point_index, feature_index, feature_value,
                  class_label, input ready);
  modport sink (input valid, cmd, point_index, feature_index, feature_value,
                class_label, output ready);
endinterface

interface kac_out_if;
  logic       valid;
  logic       ready;
  logic       same_class;
  logic [7:0] nearest_label;
  logic       count_error;

  modport source (output valid, same_class, nearest_label, count_error,
                  input ready);
  modport sink (input valid, same_class, nearest_label, count_error,
                output ready);
endinterface

// ----- rtl/kac_cell.sv -----
// ----------------------------------------------------------------------------
// kac_cell
// One slot of the sorted best list; shifts right on insertion ahead of it.
// ----------------------------------------------------------------------------
module kac_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  kac_pkg::kac_entry_t ins_i,
  input  kac_pkg::kac_entry_t left_i,
  input  logic                left_lt_i,
  output kac_pkg::kac_entry_t own_o,
  output logic                lt_o
);
  import kac_pkg::*;

  kac_entry_t ent_q, ent_d;

  // new entry orders before this one (an empty slot is after everything)
  assign lt_o = !ent_q.vld || (ins_i.dsum < ent_q.dsum) ||
                ((ins_i.dsum == ent_q.dsum) && (ins_i.lab < ent_q.lab));
  assign own_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (clear_i) begin
      ent_d.vld  = 1'b0;
      ent_d.dsum = '1;
      ent_d.lab  = '0;
    end else if (ins_i.vld && lt_o) begin
      if (left_lt_i) begin
        ent_d = left_i;
      end else begin
        ent_d = ins_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.vld  <= 1'b0;
      ent_q.dsum <= '1;
      ent_q.lab  <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

// ----- rtl/kac_engine.sv -----
// ----------------------------------------------------------------------------
// kac_engine
// Reference/query storage and the distance pipeline: one element per cycle.
// ----------------------------------------------------------------------------
module kac_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ref_we_i,
  input  logic                          lab_we_i,
  input  logic                          qry_we_i,
  input  logic [kac_pkg::PIDX_W-1:0]    wr_pidx_i,
  input  logic [kac_pkg::FIDX_W-1:0]    wr_fidx_i,
  input  logic [kac_pkg::FEAT_W-1:0]    wr_feat_i,
  input  logic [kac_pkg::LABEL_W-1:0]   wr_lab_i,
  input  logic                          start_i,
  input  logic [kac_pkg::NPTS_W-1:0]    npts_i,
  input  logic [kac_pkg::NFEAT_W-1:0]   nfeat_i,
  output kac_pkg::kac_entry_t           ins_o,
  output logic                          end_o
);
  import kac_pkg::*;

  logic [FEAT_W-1:0]  ref_mem [MAX_POINTS*MAX_FEATURES];
  logic [LABEL_W-1:0] lab_mem [MAX_POINTS];
  logic [FEAT_W-1:0]  qry_mem [MAX_FEATURES];

  logic              busy_q;
  logic [PIDX_W-1:0] p_q;
  logic [FIDX_W-1:0] f_q;
  logic              last_f, last_p;

  assign last_f = ({1'b0, f_q} == nfeat_i - NFEAT_W'(1));
  assign last_p = ({1'b0, p_q} == npts_i - NPTS_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      p_q    <= '0;
      f_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      p_q    <= '0;
      f_q    <= '0;
    end else if (busy_q) begin
      if (last_f) begin
        f_q <= '0;
        p_q <= p_q + PIDX_W'(1);
        if (last_p) begin
          busy_q <= 1'b0;
        end
      end else begin
        f_q <= f_q + FIDX_W'(1);
      end
    end
  end

  // stage 1: memory reads
  logic [FEAT_W-1:0]  rf1_q, qf1_q;
  logic [LABEL_W-1:0] lab1_q;
  logic v1_q, first1_q, lf1_q, end1_q;

  always_ff @(posedge clk_i) begin
    if (ref_we_i) begin
      ref_mem[{wr_pidx_i, wr_fidx_i}] <= wr_feat_i;
    end
    rf1_q <= ref_mem[{p_q, f_q}];
  end

  always_ff @(posedge clk_i) begin
    if (lab_we_i) begin
      lab_mem[wr_pidx_i] <= wr_lab_i;
    end
    lab1_q <= lab_mem[p_q];
  end

  always_ff @(posedge clk_i) begin
    if (qry_we_i) begin
      qry_mem[wr_fidx_i] <= wr_feat_i;
    end
    qf1_q <= qry_mem[f_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      lf1_q    <= 1'b0;
      end1_q   <= 1'b0;
    end else begin
      v1_q     <= busy_q;
      first1_q <= (f_q == '0);
      lf1_q    <= last_f;
      end1_q   <= last_f && last_p;
    end
  end

  // stage 2: square of the difference
  logic signed [FEAT_W:0] diff;
  logic signed [SQ_W-1:0] diff_x;
  logic [SQ_W-1:0]    sq2_q;
  logic [LABEL_W-1:0] lab2_q;
  logic v2_q, first2_q, lf2_q, end2_q;

  assign diff   = {qf1_q[FEAT_W-1], qf1_q} - {rf1_q[FEAT_W-1], rf1_q};
  // widen before squaring so the product keeps all its bits
  assign diff_x = SQ_W'(diff);

  always_ff @(posedge clk_i) begin
    sq2_q  <= $unsigned(diff_x * diff_x);
    lab2_q <= lab1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q     <= 1'b0;
      first2_q <= 1'b0;
      lf2_q    <= 1'b0;
      end2_q   <= 1'b0;
    end else begin
      v2_q     <= v1_q;
      first2_q <= first1_q;
      lf2_q    <= lf1_q;
      end2_q   <= end1_q;
    end
  end

  // stage 3: saturating accumulate, hand finished points to the list
  logic [DIST_W-1:0]  acc_q, acc_d;
  logic [DIST_W:0]    sum;
  logic [DIST_W-1:0]  ins_dsum_q;
  logic [LABEL_W-1:0] ins_lab_q;
  logic               ins_vld_q;
  logic               end_q;

  assign sum   = {1'b0, (first2_q ? {DIST_W{1'b0}} : acc_q)} + (DIST_W + 1)'(sq2_q);
  assign acc_d = sum[DIST_W] ? '1 : sum[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      acc_q <= acc_d;
    end
    ins_dsum_q <= acc_d;
    ins_lab_q  <= lab2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_vld_q <= 1'b0;
      end_q     <= 1'b0;
    end else begin
      ins_vld_q <= v2_q && lf2_q;
      end_q     <= v2_q && end2_q;
    end
  end

  assign ins_o = '{vld: ins_vld_q, dsum: ins_dsum_q, lab: ins_lab_q};
  assign end_o = end_q;

endmodule

// ----- rtl/knn_label_agreement_check_top.sv -----
// ----------------------------------------------------------------------------
// knn_label_agreement_check_top
// k-nearest-neighbor label agreement over stored reference points.
// ----------------------------------------------------------------------------
//  channel   dir  kind             item
//  in_i      in   valid/ready      load feature, load label, query feature
//  out_o     out  valid/ready      same_class, nearest_label, count_error
//  apb       in   APB write/read   neighbor_count, point_count, feature_count
//
//  Load items and non-final query features are taken whenever ready is high.
//  The final query feature, unless k exceeds point_count, starts a walk of
//  point_count*feature_count elements: one feature of one point per cycle
//  from the reference memory port, via read, square, accumulate, list stages.
//  No item is accepted during a query walk. No clearing pass after reset.
// ----------------------------------------------------------------------------
module knn_label_agreement_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  kac_in_if.sink      in_i,
  kac_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kac_pkg::*;

  logic [K_W-1:0]     k_q;
  logic [NPTS_W-1:0]  npts_q;
  logic [NFEAT_W-1:0] nfeat_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= K_W'(1);
      npts_q  <= NPTS_W'(1);
      nfeat_q <= NFEAT_W'(1);
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_NEIGHBOR_COUNT: k_q     <= pwdata[K_W-1:0];
        REG_POINT_COUNT:    npts_q  <= pwdata[NPTS_W-1:0];
        REG_FEATURE_COUNT:  nfeat_q <= pwdata[NFEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NEIGHBOR_COUNT: prdata = 32'(k_q);
      REG_POINT_COUNT:    prdata = 32'(npts_q);
      REG_FEATURE_COUNT:  prdata = 32'(nfeat_q);
      default:            prdata = '0;
    endcase
  end

  // effective counts
  logic [K_W-1:0]     k_eff;
  logic [NPTS_W-1:0]  npts_eff;
  logic [NFEAT_W-1:0] nfeat_eff;

  always_comb begin
    k_eff = k_q;
    if (k_q == '0) k_eff = K_W'(1);
    if (k_q > K_W'(MAX_K)) k_eff = K_W'(MAX_K);
    npts_eff = (npts_q > NPTS_W'(MAX_POINTS)) ? NPTS_W'(MAX_POINTS) : npts_q;
    nfeat_eff = nfeat_q;
    if (nfeat_q == '0) nfeat_eff = NFEAT_W'(1);
    if (nfeat_q > NFEAT_W'(MAX_FEATURES)) nfeat_eff = NFEAT_W'(MAX_FEATURES);
  end

  // input decode
  logic run_q, fin_q;
  logic out_valid_q, out_same_q, out_err_q;
  logic [LABEL_W-1:0] out_lab_q;
  logic acc, is_query, last_feat, cnt_err, start;

  assign in_i.ready = !run_q && (!out_valid_q || out_o.ready);
  assign acc       = in_i.valid && in_i.ready;
  assign is_query  = acc && (in_i.cmd == CMD_QUERY);
  assign last_feat = is_query && ({1'b0, in_i.feature_index} == nfeat_eff - NFEAT_W'(1));
  assign cnt_err   = {{(NPTS_W-K_W){1'b0}}, k_eff} > npts_eff;
  assign start     = last_feat && !cnt_err;

  kac_entry_t ins;
  logic       end_pulse;

  kac_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ref_we_i  (acc && (in_i.cmd == CMD_REF_FEAT)),
    .lab_we_i  (acc && (in_i.cmd == CMD_REF_LABEL)),
    .qry_we_i  (is_query),
    .wr_pidx_i (in_i.point_index),
    .wr_fidx_i (in_i.feature_index),
    .wr_feat_i (in_i.feature_value),
    .wr_lab_i  (in_i.class_label),
    .start_i   (start),
    .npts_i    (npts_eff),
    .nfeat_i   (nfeat_eff),
    .ins_o     (ins),
    .end_o     (end_pulse)
  );

  // sorted best list
  kac_entry_t own  [MAX_K];
  logic       lt   [MAX_K];

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    kac_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (start),
      .ins_i     (ins),
      .left_i    ((i == 0) ? own[0] : own[(i == 0) ? 0 : i-1]),
      .left_lt_i ((i == 0) ? 1'b0 : lt[(i == 0) ? 0 : i-1]),
      .own_o     (own[i]),
      .lt_o      (lt[i])
    );
  end

  logic same;
  always_comb begin
    same = 1'b1;
    for (int i = 1; i < MAX_K; i++) begin
      if ((i < int'(k_eff)) && (own[i].lab != own[0].lab)) same = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fin_q <= end_pulse;
      if (start) begin
        run_q <= 1'b1;
      end else if (fin_q) begin
        run_q <= 1'b0;
      end
      if ((last_feat && cnt_err) || fin_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_feat && cnt_err) begin
      out_same_q <= 1'b0;
      out_lab_q  <= '0;
      out_err_q  <= 1'b1;
    end else if (fin_q) begin
      out_same_q <= same;
      out_lab_q  <= own[0].lab;
      out_err_q  <= 1'b0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.same_class    = out_same_q;
  assign out_o.nearest_label = out_lab_q;
  assign out_o.count_error   = out_err_q;

endmodule
